FILE: rtl/core/hsd_pkg.sv
//==============================================================================
// hsd_pkg
// Shared constants and types for the sequence distance block.
//==============================================================================
`default_nettype none

package hsd_pkg;

    localparam int LEN_MAX     = 1024;
    localparam int SYMBOL_BITS = 16;

    // fixed field widths
    localparam int SYM_W  = 16;
    localparam int DIST_W = 22;
    localparam int MIS_W  = 11;
    localparam int LEN_W  = 11;

    localparam int IN_DATA_W  = 2 * SYM_W;
    localparam int OUT_RAW_W  = DIST_W + MIS_W + LEN_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam int CMP_BITS = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

    // counter width holds LEN_MAX itself
    localparam int CNT_W = $clog2(LEN_MAX + 1);

    // divider: numerator m * 2^32
    localparam int NUM_W = CNT_W + 32;
    // square root: radicand up to m * 2^33
    localparam int RAD_W  = 2 * ((CNT_W + 34) / 2);
    localparam int ROOT_W = RAD_W / 2;

    localparam int STEP_N = (NUM_W > ROOT_W) ? NUM_W : ROOT_W;
    localparam int STEP_W = $clog2(STEP_N + 1);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef struct packed {
        logic             norm;
        logic             ovf;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] mis;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/core/hsd_front.sv
//==============================================================================
// hsd_front
// Accepts symbol pairs, keeps the running counts, posts a job on the last word.
//==============================================================================
`default_nettype none

module hsd_front import hsd_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_data,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  wire logic                 i_s_axis_tlast,
    output logic                      o_push_valid,
    output t_job                      o_push_job,
    input  wire logic                 i_push_ready
);

    logic             r_norm;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_mis;
    logic             r_ovf;
    logic [CNT_W-1:0] n_pos;
    logic [CNT_W-1:0] n_mis;
    logic             n_ovf;
    logic             w_accept;
    logic             w_diff;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = i_push_ready;
    assign w_accept        = i_s_axis_tvalid && i_push_ready;
    assign w_diff = i_s_axis_tdata[CMP_BITS-1:0] != i_s_axis_tdata[SYM_W +: CMP_BITS];

    always_comb begin
        n_pos = r_pos;
        n_mis = r_mis;
        n_ovf = r_ovf;
        if (w_accept) begin
            if (r_pos < CNT_W'(LEN_MAX)) begin
                n_pos = r_pos + 1'b1;
                if (w_diff && (r_mis < CNT_W'(LEN_MAX))) begin
                    n_mis = r_mis + 1'b1;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_push_valid    = w_accept && i_s_axis_tlast;
    assign o_push_job.norm = r_norm;
    assign o_push_job.ovf  = n_ovf;
    assign o_push_job.len  = n_pos;
    assign o_push_job.mis  = n_mis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b1;
            r_pos  <= '0;
            r_mis  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_norm <= i_cfg_data;
            end
            if (o_push_valid) begin
                r_pos <= '0;
                r_mis <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_pos <= n_pos;
                r_mis <= n_mis;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsd_queue.sv
//==============================================================================
// hsd_queue
// Short job queue between the counting front and the arithmetic back.
//==============================================================================
`default_nettype none

module hsd_queue import hsd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    input  wire t_job i_push_job,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_job      o_pop_job,
    input  wire logic i_pop_ready
);

    t_job            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = r_cnt != (Q_AW+1)'(Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_job    = r_slot[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/hsd_back.sv
//==============================================================================
// hsd_back
// Bit-serial divider and square root, followed by the result register.
//==============================================================================
`default_nettype none

module hsd_back import hsd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_pop_valid,
    input  wire t_job                  i_pop_job,
    output logic                       o_pop_ready,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // distance_q16, mismatch_total, sequence_length
    output logic                       o_m_axis_tuser   // length_overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]            r_state;
    logic [STEP_W-1:0]     r_step;
    logic [CNT_W-1:0]      r_mis;
    logic [CNT_W-1:0]      r_len;
    logic                  r_ovf;
    logic [NUM_W-1:0]      r_num;
    logic [NUM_W-1:0]      r_quo;
    logic [CNT_W-1:0]      r_drem;
    logic [RAD_W-1:0]      r_rad;
    logic [ROOT_W:0]       r_srem;
    logic [ROOT_W-1:0]     r_root;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;

    logic [CNT_W:0]        w_dtry;
    logic                  w_dge;
    logic [CNT_W:0]        w_ddiff;
    logic [NUM_W-1:0]      w_quo;
    logic [ROOT_W+2:0]     w_stry;
    logic [ROOT_W+2:0]     w_trial;
    logic                  w_sge;
    logic [ROOT_W+2:0]     w_sdiff;
    logic                  w_load_out;

    assign o_pop_ready = r_state == ST_IDLE;

    assign w_dtry  = {r_drem, r_num[NUM_W-1]};
    assign w_dge   = w_dtry >= {1'b0, r_len};
    assign w_ddiff = w_dtry - {1'b0, r_len};
    assign w_quo   = {r_quo[NUM_W-2:0], w_dge};

    assign w_stry  = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_sge   = w_stry >= w_trial;
    assign w_sdiff = w_stry - w_trial;

    assign w_load_out = (r_state == ST_HOLD) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_mis  <= i_pop_job.mis;
                r_len  <= i_pop_job.len;
                r_ovf  <= i_pop_job.ovf;
                r_num  <= {i_pop_job.mis, 32'b0};
                r_quo  <= '0;
                r_drem <= '0;
                r_rad  <= RAD_W'({i_pop_job.mis, 33'b0});
                r_srem <= '0;
                r_root <= '0;
            end
            ST_DIV: begin
                r_drem <= w_dge ? w_ddiff[CNT_W-1:0] : w_dtry[CNT_W-1:0];
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quo  <= w_quo;
                r_rad  <= RAD_W'(w_quo);
            end
            ST_SQRT: begin
                r_srem <= w_sge ? w_sdiff[ROOT_W:0] : w_stry[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], w_sge};
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            end
            default: begin
                r_srem <= r_srem;
            end
        endcase
        if (w_load_out) begin
            r_out_data <= OUT_DATA_W'({LEN_W'(r_len), MIS_W'(r_mis), DIST_W'(r_root)});
            r_out_user <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_state <= i_pop_job.norm ? ST_DIV : ST_SQRT;
                        r_step  <= i_pop_job.norm ? STEP_W'(NUM_W - 1) : STEP_W'(ROOT_W - 1);
                    end
                end
                ST_DIV: begin
                    if (r_step == '0) begin
                        r_state <= ST_SQRT;
                        r_step  <= STEP_W'(ROOT_W - 1);
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (r_step == '0) begin
                        r_state <= ST_HOLD;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                ST_HOLD: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

FILE: rtl/core/hamming_sqrt_sequence_distance.sv
//==============================================================================
// hamming_sqrt_sequence_distance
// Normalized Hamming / Euclidean distance of two aligned symbol streams.
//==============================================================================
// Input stream: one aligned symbol pair per word, symbol_a in tdata[15:0],
// symbol_b in tdata[31:16], tlast on the final position of the pair. Words
// that are not last are taken one per cycle while the job queue has room.
// Config channel: one bit, normalize_by_length (reset 1); always ready.
// Output stream: one word per pair, sent after the last input word.
// With normalization the result comes from a serial divide, one quotient bit
// per cycle, then a serial square root, one root bit per cycle; without it,
// only the serial square root runs, on the mismatch count times 2^33.
// A new pair is counted while the previous one is still in the divider or
// square root; two finished pairs can wait in the job queue, after which
// tready drops until the arithmetic unit takes the next job.
// Reset clears counters, queue and output valid and sets normalization on.
// A stalled output holds its word; the unit stops in its final step until the
// output register frees, and the input stalls once the queue is full.
//==============================================================================
`default_nettype none

module hamming_sqrt_sequence_distance import hsd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_data,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // symbol_a, symbol_b
    input  wire logic                  i_s_axis_tlast,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,   // distance_q16, mismatch_total, sequence_length
    output logic                       o_m_axis_tuser    // length_overflow
);

    logic w_push_valid;
    t_job w_push_job;
    logic w_push_ready;
    logic w_pop_valid;
    t_job w_pop_job;
    logic w_pop_ready;

    hsd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_push_valid    (w_push_valid),
        .o_push_job      (w_push_job),
        .i_push_ready    (w_push_ready)
    );

    hsd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job),
        .i_pop_ready  (w_pop_ready)
    );

    hsd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pop_valid     (w_pop_valid),
        .i_pop_job       (w_pop_job),
        .o_pop_ready     (w_pop_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: rtl/core/hsd_checker.sv
//==============================================================================
// hsd_checker
// Port-level checks on the result stream of the distance block.
//==============================================================================
`default_nettype none

module hsd_checker import hsd_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tuser
);

    logic [DIST_W-1:0] w_dist;
    logic [MIS_W-1:0]  w_mis;
    logic [LEN_W-1:0]  w_len;

    assign w_dist = o_m_axis_tdata[DIST_W-1:0];
    assign w_mis  = o_m_axis_tdata[DIST_W +: MIS_W];
    assign w_len  = o_m_axis_tdata[DIST_W + MIS_W +: LEN_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_mis_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_mis <= w_len) && (w_len != '0))
        else $error("mismatch count above length or empty length");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> w_len == LEN_W'(LEN_MAX))
        else $error("overflow flagged below full length");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_mis == '0) == (w_dist == '0)))
        else $error("distance disagrees with mismatch count");

endmodule

bind hamming_sqrt_sequence_distance hsd_checker u_hsd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
